// ===== rtl/core/asfrm_pkg.sv =====
// Shared constants, types and pointer helpers for the audio sample FIFO with RMS meter.
package asfrm_pkg;

   // Ring and burst sizing
   localparam int DEPTH     = 32768;
   localparam int MAX_BLOCK = 4096;
   localparam int MAX_BURST = 64;

   // Field widths
   localparam int SAMPLE_W = 16;
   localparam int MAXC_W   = 7;
   localparam int LEVEL_W  = 16;
   localparam int FILL_W   = 16;

   // Meter widths
   localparam int SQ_W     = 2 * SAMPLE_W;
   localparam int SUM_W    = 43;
   localparam int CNT_W    = 13;
   localparam int RAD_W    = SUM_W + (SUM_W % 2);
   localparam int ROOT_W   = RAD_W / 2;
   localparam int SREM_W   = ROOT_W + 3;
   localparam int DREM_W   = CNT_W + 1;
   localparam int STEP_W   = $clog2(SUM_W + 1);

   // Ring pointer widths: pointers wrap modulo twice the depth
   localparam int SPAN    = 2 * DEPTH;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int PTR_W   = $clog2(SPAN);
   localparam int BURST_W = $clog2(MAX_BURST + 1);
   localparam int CMP_W   = (PTR_W > BURST_W) ? PTR_W : BURST_W;

   // Command queue between front and back
   localparam int CMDQ_AW    = 1;
   localparam int CMDQ_DEPTH = 2 ** CMDQ_AW;

   typedef enum logic [0:0] {
      OP_PUSH = 1'b0,
      OP_READ = 1'b1
   } op_type;

   typedef struct packed {
      op_type                      op;
      logic signed [SAMPLE_W-1:0]  sample;
      logic                        block_end;
      logic [BURST_W-1:0]          count;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ACCUM,
      ST_METER,
      ST_EMIT,
      ST_RD_ADDR,
      ST_RD_DATA
   } back_state_type;

   typedef enum logic [1:0] {
      MS_IDLE,
      MS_DIV,
      MS_SQRT,
      MS_DONE
   } meter_state_type;

   // Advance a ring pointer, wrapping at twice the depth
   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      if (p == PTR_W'(SPAN - 1)) r = '0;
      else                       r = p + 1'b1;
      return r;
   endfunction

   // Map a pointer onto a ring address
   function automatic logic [ADDR_W-1:0] ptr_index(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      if (p >= PTR_W'(DEPTH)) r = p - PTR_W'(DEPTH);
      else                    r = p;
      return r[ADDR_W-1:0];
   endfunction

   // Entries held between read and write pointers
   function automatic logic [PTR_W-1:0] ptr_fill(input logic [PTR_W-1:0] w,
                                                 input logic [PTR_W-1:0] r);
      logic [PTR_W:0] t;
      if (w >= r) t = {1'b0, w} - {1'b0, r};
      else        t = {1'b0, w} + (PTR_W+1)'(SPAN) - {1'b0, r};
      return t[PTR_W-1:0];
   endfunction

endpackage

// ===== rtl/core/asfrm_front.sv =====
// Front end: accepts request transfers, classifies them and queues commands for the back end.
module asfrm_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   output logic                           full,
   input  logic                           req_kind,
   input  logic signed [15:0]             req_sample,
   input  logic                           req_block_end,
   input  logic [6:0]                     req_max_count,
   output asfrm_pkg::cmd_type             cmd,
   output logic                           cmd_valid,
   input  logic                           cmd_take
);
   import asfrm_pkg::*;

   cmd_type              q_ff [CMDQ_DEPTH];
   logic [CMDQ_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [CMDQ_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CMDQ_AW:0]     cnt_ff, cnt_in;
   cmd_type              new_cmd;
   logic                 accept;
   logic                 take;

   // Classify the incoming item and clamp its burst length
   always_comb begin
      new_cmd.op        = req_kind ? OP_READ : OP_PUSH;
      new_cmd.sample    = req_sample;
      new_cmd.block_end = req_block_end;
      if (req_max_count > MAXC_W'(MAX_BURST)) new_cmd.count = BURST_W'(MAX_BURST);
      else                                    new_cmd.count = BURST_W'(req_max_count);
   end

   assign full      = (cnt_ff == (CMDQ_AW+1)'(CMDQ_DEPTH));
   assign cmd_valid = (cnt_ff != '0);
   assign cmd       = q_ff[rd_ptr_ff];
   assign accept    = push && !full;
   assign take      = cmd_take && cmd_valid;

   // Advance queue pointers and occupancy
   always_comb begin
      wr_ptr_in = accept ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = take   ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff + (CMDQ_AW+1)'(accept) - (CMDQ_AW+1)'(take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Store the accepted command
   always_ff @(posedge clock) begin
      if (accept) q_ff[wr_ptr_ff] <= new_cmd;
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (CMDQ_AW+1)'(CMDQ_DEPTH))
      else $error("command queue over capacity");

   a_no_take_empty: assert property (@(posedge clock) disable iff (reset)
      cmd_take |-> cmd_valid)
      else $error("command taken from empty queue");

   a_cnt_track: assert property (@(posedge clock) disable iff (reset)
      (accept && !take) |=> cnt_ff == $past(cnt_ff) + 1'b1)
      else $error("queue count lost a transfer");

endmodule

// ===== rtl/core/asfrm_meter.sv =====
// Iterative mean-square divider and integer square root for the block level.
module asfrm_meter (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [asfrm_pkg::SUM_W-1:0]        sum_value,
   input  logic [asfrm_pkg::CNT_W-1:0]        sum_count,
   output logic                               done,
   output logic [asfrm_pkg::LEVEL_W-1:0]      level
);
   import asfrm_pkg::*;

   meter_state_type     state_ff, state_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [SUM_W-1:0]    quo_ff, quo_in;
   logic [DREM_W-1:0]   drem_ff, drem_in;
   logic [CNT_W-1:0]    div_ff, div_in;
   logic                zero_ff, zero_in;
   logic [RAD_W-1:0]    rad_ff, rad_in;
   logic [ROOT_W-1:0]   root_ff, root_in;
   logic [SREM_W-1:0]   srem_ff, srem_in;
   logic [DREM_W-1:0]   drem_try;
   logic [SREM_W-1:0]   srem_try;
   logic [SREM_W-1:0]   trial;

   // One quotient bit or one root bit per cycle
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      quo_in   = quo_ff;
      drem_in  = drem_ff;
      div_in   = div_ff;
      zero_in  = zero_ff;
      rad_in   = rad_ff;
      root_in  = root_ff;
      srem_in  = srem_ff;
      done     = 1'b0;
      level    = '0;
      drem_try = {drem_ff[DREM_W-2:0], quo_ff[SUM_W-1]};
      srem_try = {srem_ff[SREM_W-3:0], rad_ff[RAD_W-1:RAD_W-2]};
      trial    = {1'b0, root_ff, 2'b01};

      unique case (state_ff)
         MS_IDLE: begin
            if (start) begin
               quo_in   = sum_value;
               drem_in  = '0;
               div_in   = sum_count;
               zero_in  = (sum_count == '0);
               step_in  = STEP_W'(SUM_W - 1);
               state_in = MS_DIV;
            end
         end
         MS_DIV: begin
            if (drem_try >= {1'b0, div_ff}) begin
               drem_in = drem_try - {1'b0, div_ff};
               quo_in  = {quo_ff[SUM_W-2:0], 1'b1};
            end else begin
               drem_in = drem_try;
               quo_in  = {quo_ff[SUM_W-2:0], 1'b0};
            end
            if (step_ff == '0) begin
               state_in = MS_SQRT;
               step_in  = STEP_W'(ROOT_W - 1);
               rad_in   = RAD_W'(quo_in);
               root_in  = '0;
               srem_in  = '0;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         MS_SQRT: begin
            if (srem_try >= trial) begin
               srem_in = srem_try - trial;
               root_in = {root_ff[ROOT_W-2:0], 1'b1};
            end else begin
               srem_in = srem_try;
               root_in = {root_ff[ROOT_W-2:0], 1'b0};
            end
            rad_in = {rad_ff[RAD_W-3:0], 2'b00};
            if (step_ff == '0) state_in = MS_DONE;
            else               step_in  = step_ff - 1'b1;
         end
         MS_DONE: begin
            done     = 1'b1;
            state_in = MS_IDLE;
            // Saturate the root to the level width; an empty block reads zero
            if (zero_ff)                          level = '0;
            else if (|root_ff[ROOT_W-1:LEVEL_W])  level = '1;
            else                                  level = root_ff[LEVEL_W-1:0];
         end
         default: state_in = MS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= MS_IDLE;
      else       state_ff <= state_in;
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      quo_ff  <= quo_in;
      drem_ff <= drem_in;
      div_ff  <= div_in;
      zero_ff <= zero_in;
      rad_ff  <= rad_in;
      root_ff <= root_in;
      srem_ff <= srem_in;
   end

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      (start && state_ff != MS_IDLE) |-> 1'b0)
      else $error("meter started while busy");

   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      (state_ff == MS_DIV && !zero_ff) |-> drem_ff < {1'b0, div_ff})
      else $error("divider remainder not below divisor");

   a_done_once: assert property (@(posedge clock) disable iff (reset)
      done |=> !done)
      else $error("meter done held for more than one cycle");

endmodule

// ===== rtl/core/asfrm_back.sv =====
// Back end: sample ring, block metering, read bursts and the result register.
module asfrm_back (
   input  logic                              clock,
   input  logic                              reset,
   input  asfrm_pkg::cmd_type                cmd,
   input  logic                              cmd_valid,
   output logic                              cmd_take,
   input  logic                              csr_wr_en,
   input  logic                              csr_wr_data,
   output logic                              empty,
   input  logic                              pop,
   output logic signed [15:0]                rsp_sample_out,
   output logic                              rsp_has_sample,
   output logic                              rsp_last,
   output logic [15:0]                       rsp_level,
   output logic [15:0]                       rsp_fill
);
   import asfrm_pkg::*;

   // Sample ring
   logic signed [SAMPLE_W-1:0] ring_mem [DEPTH];
   logic signed [SAMPLE_W-1:0] rd_data_ff;
   logic                       ring_we;

   back_state_type        state_ff, state_in;
   cmd_type               cmd_ff, cmd_in;
   logic [SQ_W-1:0]       sq_ff, sq_in;
   logic [PTR_W-1:0]      wptr_ff, wptr_in;
   logic [PTR_W-1:0]      rptr_ff, rptr_in;
   logic [SUM_W-1:0]      sum_ff, sum_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [LEVEL_W-1:0]    level_ff, level_in;
   logic [BURST_W-1:0]    remain_ff, remain_in;
   logic                  enable_ff, enable_in;

   // Result register
   logic                        out_valid_ff, out_valid_in;
   logic signed [SAMPLE_W-1:0]  out_sample_ff, out_sample_in;
   logic                        out_has_ff, out_has_in;
   logic                        out_last_ff, out_last_in;
   logic [LEVEL_W-1:0]          out_level_ff, out_level_in;
   logic [FILL_W-1:0]           out_fill_ff, out_fill_in;
   logic                        out_load;
   logic                        out_free;

   logic                        meter_start;
   logic                        meter_done;
   logic [LEVEL_W-1:0]          meter_level;
   logic [SUM_W-1:0]            sum_next;
   logic [CNT_W-1:0]            cnt_next;
   logic [PTR_W-1:0]            fill;
   logic [CMP_W-1:0]            avail;
   logic [CMP_W-1:0]            want;
   logic [BURST_W-1:0]          burst;
   logic signed [SQ_W-1:0]      product;

   asfrm_meter u_meter (
      .clock     (clock),
      .reset     (reset),
      .start     (meter_start),
      .sum_value (sum_next),
      .sum_count (cnt_next),
      .done      (meter_done),
      .level     (meter_level)
   );

   assign fill     = ptr_fill(wptr_ff, rptr_ff);
   assign out_free = !out_valid_ff || pop;
   assign product  = cmd.sample * cmd.sample;

   // Burst length: requested count limited by what the ring holds
   always_comb begin
      avail = enable_ff ? CMP_W'(fill) : '0;
      want  = CMP_W'(cmd.count);
      if (want <= avail) burst = cmd.count;
      else               burst = avail[BURST_W-1:0];
   end

   // Block sum and count after this push
   always_comb begin
      if (cnt_ff < CNT_W'(MAX_BLOCK)) begin
         sum_next = sum_ff + SUM_W'(sq_ff);
         cnt_next = cnt_ff + 1'b1;
      end else begin
         sum_next = sum_ff;
         cnt_next = cnt_ff;
      end
   end

   // Sequence one command at a time
   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      sq_in         = sq_ff;
      wptr_in       = wptr_ff;
      rptr_in       = rptr_ff;
      sum_in        = sum_ff;
      cnt_in        = cnt_ff;
      level_in      = level_ff;
      remain_in     = remain_ff;
      enable_in     = enable_ff;
      cmd_take      = 1'b0;
      ring_we       = 1'b0;
      meter_start   = 1'b0;
      out_load      = 1'b0;
      out_sample_in = '0;
      out_has_in    = 1'b0;
      out_last_in   = 1'b1;
      out_level_in  = level_ff;
      out_fill_in   = FILL_W'(fill);

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_take = 1'b1;
               cmd_in   = cmd;
               sq_in    = unsigned'(product);
               if (cmd.op == OP_PUSH) begin
                  // Drop pushes while capture is closed
                  if (enable_ff) state_in = ST_ACCUM;
               end else if (burst == '0) begin
                  state_in = ST_EMIT;
               end else begin
                  remain_in = burst;
                  state_in  = ST_RD_ADDR;
               end
            end
         end
         ST_ACCUM: begin
            sum_in = sum_next;
            cnt_in = cnt_next;
            if (fill != PTR_W'(DEPTH)) begin
               ring_we = 1'b1;
               wptr_in = ptr_inc(wptr_ff);
            end
            if (cmd_ff.block_end) begin
               meter_start = 1'b1;
               sum_in      = '0;
               cnt_in      = '0;
               state_in    = ST_METER;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_METER: begin
            if (meter_done) begin
               level_in = meter_level;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_RD_ADDR: begin
            state_in = ST_RD_DATA;
         end
         ST_RD_DATA: begin
            if (out_free) begin
               out_load      = 1'b1;
               out_sample_in = rd_data_ff;
               out_has_in    = 1'b1;
               out_last_in   = (remain_ff == BURST_W'(1));
               out_fill_in   = FILL_W'(ptr_fill(wptr_ff, ptr_inc(rptr_ff)));
               rptr_in       = ptr_inc(rptr_ff);
               remain_in     = remain_ff - 1'b1;
               if (remain_ff == BURST_W'(1)) state_in = ST_IDLE;
               else                          state_in = ST_RD_ADDR;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // Opening capture restarts the ring
      if (csr_wr_en) begin
         enable_in = csr_wr_data;
         if (!enable_ff && csr_wr_data) begin
            wptr_in = '0;
            rptr_in = '0;
         end
      end
   end

   // Hold or release the result register
   always_comb begin
      if (out_load)  out_valid_in = 1'b1;
      else if (pop)  out_valid_in = 1'b0;
      else           out_valid_in = out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wptr_ff      <= '0;
         rptr_ff      <= '0;
         sum_ff       <= '0;
         cnt_ff       <= '0;
         level_ff     <= '0;
         remain_ff    <= '0;
         enable_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wptr_ff      <= wptr_in;
         rptr_ff      <= rptr_in;
         sum_ff       <= sum_in;
         cnt_ff       <= cnt_in;
         level_ff     <= level_in;
         remain_ff    <= remain_in;
         enable_ff    <= enable_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Command and result payload
   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      sq_ff  <= sq_in;
      if (out_load) begin
         out_sample_ff <= out_sample_in;
         out_has_ff    <= out_has_in;
         out_last_ff   <= out_last_in;
         out_level_ff  <= out_level_in;
         out_fill_ff   <= out_fill_in;
      end
   end

   // Ring write and registered read
   always_ff @(posedge clock) begin
      if (ring_we) ring_mem[ptr_index(wptr_ff)] <= cmd_ff.sample;
      rd_data_ff <= ring_mem[ptr_index(rptr_ff)];
   end

   assign empty          = !out_valid_ff;
   assign rsp_sample_out = out_sample_ff;
   assign rsp_has_sample = out_has_ff;
   assign rsp_last       = out_last_ff;
   assign rsp_level      = out_level_ff;
   assign rsp_fill       = out_fill_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill <= PTR_W'(DEPTH))
      else $error("ring fill exceeds depth");

   a_write_room: assert property (@(posedge clock) disable iff (reset)
      ring_we |-> fill < PTR_W'(DEPTH))
      else $error("ring written while full");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      out_load |-> out_free)
      else $error("result register overwritten");

   a_burst_live: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RD_ADDR || state_ff == ST_RD_DATA) |-> remain_ff != '0)
      else $error("read burst with nothing left");

   a_meter_wait: assert property (@(posedge clock) disable iff (reset)
      meter_done |-> state_ff == ST_METER)
      else $error("meter finished outside block end");

endmodule

// ===== rtl/core/audio_sample_fifo_rms_meter_core.sv =====
// Top level of the audio sample FIFO with block RMS level meter.
// A push is registered in the command queue, taken by the back end in ST_IDLE and written to the
// ring in ST_ACCUM; a block-end push yields its result via the meter (43-step divide, 22-step
// square root). A read steps through ST_RD_ADDR and ST_RD_DATA for each popped sample, as the
// ring read port is registered; the two-entry command queue takes transfers meanwhile.
// Reset clears pointers, block sum, level, capture enable and both queues; ring contents stay.
module audio_sample_fifo_rms_meter_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   output logic                 full,
   input  logic                 req_kind,
   input  logic signed [15:0]   req_sample,
   input  logic                 req_block_end,
   input  logic [6:0]           req_max_count,
   output logic                 empty,
   input  logic                 pop,
   output logic signed [15:0]   rsp_sample_out,
   output logic                 rsp_has_sample,
   output logic                 rsp_last,
   output logic [15:0]          rsp_level,
   output logic [15:0]          rsp_fill,
   input  logic                 csr_wr_en,
   input  logic                 csr_wr_data
);
   import asfrm_pkg::*;

   cmd_type  cmd;
   logic     cmd_valid;
   logic     cmd_take;

   asfrm_front u_front (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .full          (full),
      .req_kind      (req_kind),
      .req_sample    (req_sample),
      .req_block_end (req_block_end),
      .req_max_count (req_max_count),
      .cmd           (cmd),
      .cmd_valid     (cmd_valid),
      .cmd_take      (cmd_take)
   );

   asfrm_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .cmd_valid      (cmd_valid),
      .cmd_take       (cmd_take),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .empty          (empty),
      .pop            (pop),
      .rsp_sample_out (rsp_sample_out),
      .rsp_has_sample (rsp_has_sample),
      .rsp_last       (rsp_last),
      .rsp_level      (rsp_level),
      .rsp_fill       (rsp_fill)
   );

endmodule

// ===== verif/tb.sv =====
// Testbench for the audio sample FIFO with RMS meter: predicts and checks every result transfer.
`timescale 1ns / 1ps

module tb;
   import asfrm_pkg::*;

   localparam int QUIET_CYCLES = 120;
   localparam int STALL_LIMIT  = 4000;

   typedef struct {
      logic [15:0] smp;
      logic        has;
      logic        last;
      logic [15:0] lvl;
      logic [15:0] fill;
   } rsp_item_type;

   // Track ring, pointers, block meter and capture enable; hold expected results in order
   class fifo_level_tracker;
      logic [15:0]  ring [DEPTH];
      int unsigned  wr_ptr = 0;
      int unsigned  rd_ptr = 0;
      logic [42:0]  sq_sum = '0;
      int unsigned  blk_cnt = 0;
      logic [15:0]  lvl = '0;
      bit           capture_on = 1'b0;
      int unsigned  errors = 0;
      rsp_item_type due_rsp[$];

      function int unsigned held();
         return (wr_ptr + SPAN - rd_ptr) % SPAN;
      endfunction

      task report(string msg);
         errors++;
         if (errors <= 100) $display("tb: mismatch at %0t: %s", $realtime, msg);
      endtask

      function void add_rsp(logic [15:0] s, bit has, bit last);
         rsp_item_type r;
         r.smp  = s;
         r.has  = has;
         r.last = last;
         r.lvl  = lvl;
         r.fill = 16'(held());
         due_rsp.push_back(r);
      endfunction

      // Opening the capture from closed resets both pointers
      function void write_capture(bit v);
         if (!capture_on && v) begin
            wr_ptr = 0;
            rd_ptr = 0;
         end
         capture_on = v;
      endfunction

      // Largest r with r*r <= v, found one bit at a time
      function longint unsigned root_floor(longint unsigned v);
         longint unsigned r;
         longint unsigned t;
         r = 0;
         for (int b = 16; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= v) r = t;
         end
         return r;
      endfunction

      function void note_transfer(op_type kind, logic signed [15:0] s, logic bend,
                                  logic [6:0] maxc);
         longint      sq;
         int unsigned want;
         int unsigned n;
         logic [15:0] popped;
         if (kind == OP_PUSH) begin
            if (!capture_on) return;
            // Meter first: a dropped sample still counts toward the block
            sq = longint'(s) * longint'(s);
            if (blk_cnt < MAX_BLOCK) begin
               sq_sum = sq_sum + 43'(sq);
               blk_cnt++;
            end
            if (held() < DEPTH) begin
               ring[wr_ptr % DEPTH] = s;
               wr_ptr = (wr_ptr + 1) % SPAN;
            end
            if (bend) begin
               lvl = (blk_cnt == 0) ? 16'd0 : 16'(root_floor(64'(sq_sum) / blk_cnt));
               sq_sum  = '0;
               blk_cnt = 0;
               add_rsp(16'd0, 1'b0, 1'b1);
            end
         end else begin
            want = (maxc > MAX_BURST) ? MAX_BURST : maxc;
            n = capture_on ? held() : 0;
            if (want < n) n = want;
            if (n == 0) add_rsp(16'd0, 1'b0, 1'b1);
            for (int i = 0; i < n; i++) begin
               popped = ring[rd_ptr % DEPTH];
               rd_ptr = (rd_ptr + 1) % SPAN;
               add_rsp(popped, 1'b1, i == n - 1);
            end
         end
      endfunction

      task check_result(logic [15:0] s, logic has, logic last, logic [15:0] l,
                        logic [15:0] f);
         rsp_item_type e;
         if (due_rsp.size() == 0) begin
            report("result transfer with none expected");
            return;
         end
         e = due_rsp.pop_front();
         if (s !== e.smp)     report($sformatf("sample_out %h, expected %h", s, e.smp));
         if (has !== e.has)   report($sformatf("has_sample %b, expected %b", has, e.has));
         if (last !== e.last) report($sformatf("last %b, expected %b", last, e.last));
         if (l !== e.lvl)     report($sformatf("level %0d, expected %0d", l, e.lvl));
         if (f !== e.fill)    report($sformatf("fill %0d, expected %0d", f, e.fill));
      endtask
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               push = 1'b0;
   logic               full;
   logic               req_kind = 1'b0;
   logic signed [15:0] req_sample = '0;
   logic               req_block_end = 1'b0;
   logic [6:0]         req_max_count = '0;
   logic               empty;
   logic               pop = 1'b0;
   logic signed [15:0] rsp_sample_out;
   logic               rsp_has_sample;
   logic               rsp_last;
   logic [15:0]        rsp_level;
   logic [15:0]        rsp_fill;
   logic               csr_wr_en = 1'b0;
   logic               csr_wr_data = 1'b0;

   int                 send_idle_pct = 0;
   int                 take_stall_pct = 0;
   int unsigned        quiet_count = 0;
   fifo_level_tracker  tracker;

   audio_sample_fifo_rms_meter_core dut (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_kind       (req_kind),
      .req_sample     (req_sample),
      .req_block_end  (req_block_end),
      .req_max_count  (req_max_count),
      .empty          (empty),
      .pop            (pop),
      .rsp_sample_out (rsp_sample_out),
      .rsp_has_sample (rsp_has_sample),
      .rsp_last       (rsp_last),
      .rsp_level      (rsp_level),
      .rsp_fill       (rsp_fill),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   always #6 clock = ~clock;

   // Check each result transfer and choose the next pop
   always @(posedge clock) begin
      if (!reset) begin
         if (pop && !empty)
            tracker.check_result(rsp_sample_out, rsp_has_sample, rsp_last, rsp_level, rsp_fill);
         pop <= ($urandom_range(99) >= take_stall_pct);
      end
   end

   // Abort when no transfer happens on either side for too long
   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) begin
         quiet_count <= 0;
      end else if (quiet_count == STALL_LIMIT) begin
         $display("tb: errors");
         $finish;
      end else begin
         quiet_count <= quiet_count + 1;
      end
   end

   // Hold one item on the input until it transfers, then idle at random
   task automatic send_item(op_type kind, logic signed [15:0] s, logic bend,
                            logic [6:0] maxc);
      req_kind      <= kind;
      req_sample    <= s;
      req_block_end <= bend;
      req_max_count <= maxc;
      push          <= 1'b1;
      do @(posedge clock); while (full);
      tracker.note_transfer(kind, s, bend, maxc);
      if ($urandom_range(99) < send_idle_pct) begin
         push <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
   endtask

   // Drop push, wait for every expected result, then let the meter finish
   task automatic settle();
      push <= 1'b0;
      while (tracker.due_rsp.size() != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   task automatic write_capture(logic v);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      tracker.write_capture(v);
      @(posedge clock);
   endtask

   function automatic logic signed [15:0] pick_sample();
      case ($urandom_range(7))
         0:       return 16'sh7FFF;
         1:       return 16'sh8000;
         2:       return 16'($urandom_range(0, 64)) - 16'd32;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic random_items(int count);
      logic [6:0] maxc;
      repeat (count) begin
         if ($urandom_range(99) < 65) begin
            send_item(OP_PUSH, pick_sample(), ($urandom_range(9) == 0), 7'($urandom));
         end else begin
            case ($urandom_range(9))
               0, 1, 2, 3, 4: maxc = 7'($urandom_range(0, 8));
               5, 6, 7:       maxc = 7'($urandom_range(0, 64));
               default:       maxc = 7'($urandom_range(0, 127));
            endcase
            send_item(OP_READ, pick_sample(), 1'($urandom_range(1)), maxc);
         end
      end
   endtask

   initial begin
      tracker = new;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Closed capture: push ignored, read answers empty
      write_capture(1'b0);
      send_item(OP_PUSH, 16'sd1234, 1'b1, 7'd0);
      send_item(OP_READ, 16'sd0, 1'b0, 7'd3);
      settle();

      // Extremes in one block, then reads of zero, one, saturated and empty ring
      write_capture(1'b1);
      send_item(OP_PUSH, 16'sh7FFF, 1'b0, 7'd0);
      send_item(OP_PUSH, 16'sh8000, 1'b0, 7'd0);
      send_item(OP_PUSH, 16'sd0, 1'b0, 7'd0);
      send_item(OP_PUSH, -16'sd1, 1'b1, 7'd0);
      send_item(OP_READ, 16'sd0, 1'b0, 7'd0);
      send_item(OP_READ, 16'sd0, 1'b0, 7'd1);
      send_item(OP_READ, 16'sd0, 1'b0, 7'd127);
      send_item(OP_READ, 16'sd0, 1'b0, 7'd5);

      // Single-sample blocks: full scale and smallest nonzero level
      send_item(OP_PUSH, 16'sh8000, 1'b1, 7'd0);
      send_item(OP_PUSH, 16'sd1, 1'b1, 7'd0);
      send_item(OP_READ, 16'sd0, 1'b0, 7'd64);
      repeat (3) send_item(OP_PUSH, pick_sample(), 1'b0, 7'd0);
      settle();

      // Rewriting an open capture keeps the ring
      write_capture(1'b1);
      send_item(OP_READ, 16'sd0, 1'b0, 7'd64);
      settle();

      // Random traffic under each idling pattern
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0:       begin send_idle_pct = 0;  take_stall_pct = 0;  end
            1:       begin send_idle_pct = 56; take_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  take_stall_pct = 56; end
            default: begin send_idle_pct = 25; take_stall_pct = 25; end
         endcase
         random_items(24);
         if (ph == 1) settle();
         random_items(24);
         settle();
         if (ph == 2) begin
            write_capture(1'b0);
            random_items(10);
            settle();
            write_capture(1'b1);
         end
      end

      // Two short blocks back to back, then pops that drain and overrun the ring
      send_idle_pct  = 0;
      take_stall_pct = 25;
      write_capture(1'b0);
      write_capture(1'b1);
      for (int k = 0; k < 12; k++)
         send_item(OP_PUSH, pick_sample(), (k == 5 || k == 11), 7'($urandom));
      repeat (3) send_item(OP_READ, 16'sd0, 1'b0, 7'd64);
      repeat (4) send_item(OP_PUSH, pick_sample(), 1'b0, 7'd0);
      send_item(OP_READ, 16'sd0, 1'b0, 7'd100);
      settle();

      // Reopen the capture to restart the ring, then some closing traffic
      write_capture(1'b0);
      write_capture(1'b1);
      send_idle_pct  = 25;
      take_stall_pct = 25;
      random_items(20);
      settle();

      if (tracker.errors == 0) $display("tb: clean");
      else                     $display("tb: errors");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/asfrm_pkg.sv
rtl/core/asfrm_front.sv
rtl/core/asfrm_meter.sv
rtl/core/asfrm_back.sv
rtl/core/audio_sample_fifo_rms_meter_core.sv
verif/tb.sv
